@@ rtl/tbcs_pkg.sv @@
`default_nettype none
package tbcs_pkg;

    localparam int COORD_BITS       = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int CW               = (COORD_BITS < 16) ? COORD_BITS : 16;
    // edge function magnitude: products of (CW+2)-bit differences, summed
    localparam int EW               = 2 * CW + 4;
    localparam int MW               = EW - 1;
    localparam int WW               = WEIGHT_FRAC_BITS + 1;
    localparam int DIV_STEPS        = WW;
    localparam int PIPE_DEPTH       = 3 + DIV_STEPS + 2;

    localparam logic [2:0] REG_VERTEX_A_XY    = 3'd0;
    localparam logic [2:0] REG_VERTEX_B_XY    = 3'd1;
    localparam logic [2:0] REG_VERTEX_C_XY    = 3'd2;
    localparam logic [2:0] REG_VERTEX_A_RGB   = 3'd3;
    localparam logic [2:0] REG_VERTEX_B_RGB   = 3'd4;
    localparam logic [2:0] REG_VERTEX_C_RGB   = 3'd5;
    localparam logic [2:0] REG_TRIANGLE_VALID = 3'd6;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic       covered;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic [31:0] vertex_a_xy;
        logic [31:0] vertex_b_xy;
        logic [31:0] vertex_c_xy;
        logic [23:0] vertex_a_rgb;
        logic [23:0] vertex_b_rgb;
        logic [23:0] vertex_c_rgb;
        logic        triangle_valid;
    } tri_cfg_t;

    // magnitudes for the dividers and the ok flag, handed on from the edge stage
    typedef struct packed {
        logic          ok;
        logic [MW-1:0] beta_num;
        logic [MW-1:0] beta_den;
        logic [MW-1:0] gamma_num;
        logic [MW-1:0] gamma_den;
    } edge_res_t;

    function automatic logic signed [CW:0] sext_coord(input logic [15:0] v);
        logic signed [CW-1:0] t;
        t = v[CW-1:0];
        return (CW+1)'(t);
    endfunction

endpackage
`default_nettype wire

@@ rtl/tbcs_edge.sv @@
`default_nettype none
// three stages: differences, products, sums and weight range checks
module tbcs_edge (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire tbcs_pkg::pixel_t     in_pix,
    input  wire tbcs_pkg::tri_cfg_t   cfg,
    output logic                      out_valid,
    output tbcs_pkg::edge_res_t       out_res
);
    localparam int CW = tbcs_pkg::CW;
    localparam int EW = tbcs_pkg::EW;
    localparam int MW = tbcs_pkg::MW;

    logic signed [CW:0] ax, ay, bx, by, cx, cy, px, py;
    assign ax = tbcs_pkg::sext_coord(cfg.vertex_a_xy[15:0]);
    assign ay = tbcs_pkg::sext_coord(cfg.vertex_a_xy[31:16]);
    assign bx = tbcs_pkg::sext_coord(cfg.vertex_b_xy[15:0]);
    assign by = tbcs_pkg::sext_coord(cfg.vertex_b_xy[31:16]);
    assign cx = tbcs_pkg::sext_coord(cfg.vertex_c_xy[15:0]);
    assign cy = tbcs_pkg::sext_coord(cfg.vertex_c_xy[31:16]);
    assign px = tbcs_pkg::sext_coord(in_pix.pixel_x);
    assign py = tbcs_pkg::sext_coord(in_pix.pixel_y);

    // stage 1: register differences relative to c, E(p,i,c)=(iy-cy)(px-cx)-(ix-cx)(py-cy)
    logic               v1_reg, tv1_reg;
    logic signed [CW+1:0] dpx_reg, dpy_reg, dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [CW+1:0] dpx_next, dpy_next, dax_next, day_next, dbx_next, dby_next;
    assign dpx_next = (CW+2)'(px) - (CW+2)'(cx);
    assign dpy_next = (CW+2)'(py) - (CW+2)'(cy);
    assign dax_next = (CW+2)'(ax) - (CW+2)'(cx);
    assign day_next = (CW+2)'(ay) - (CW+2)'(cy);
    assign dbx_next = (CW+2)'(bx) - (CW+2)'(cx);
    assign dby_next = (CW+2)'(by) - (CW+2)'(cy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tv1_reg <= cfg.triangle_valid;
        dpx_reg <= dpx_next;
        dpy_reg <= dpy_next;
        dax_reg <= dax_next;
        day_reg <= day_next;
        dbx_reg <= dbx_next;
        dby_reg <= dby_next;
    end

    // stage 2: products
    logic                v2_reg, tv2_reg;
    logic signed [EW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tv2_reg <= tv1_reg;
        // beta num: (by-cy)dpx - (bx-cx)dpy ; beta den: (by-cy)dax - (bx-cx)day
        p0_reg <= EW'(dby_reg * dpx_reg);
        p1_reg <= EW'(dbx_reg * dpy_reg);
        p2_reg <= EW'(dby_reg * dax_reg);
        p3_reg <= EW'(dbx_reg * day_reg);
        // gamma num: (ay-cy)dpx - (ax-cx)dpy ; gamma den: (ay-cy)dbx - (ax-cx)dby
        p4_reg <= EW'(day_reg * dpx_reg);
        p5_reg <= EW'(dax_reg * dpy_reg);
        p6_reg <= EW'(day_reg * dbx_reg);
        p7_reg <= EW'(dax_reg * dby_reg);
    end

    // stage 3: sums, sign and range checks, magnitudes
    logic signed [EW-1:0] bn, bd, gn, gd;
    logic [EW-1:0] abn, abd, agn, agd;
    logic bok, gok;
    assign bn = p0_reg - p1_reg;
    assign bd = p2_reg - p3_reg;
    assign gn = p4_reg - p5_reg;
    assign gd = p6_reg - p7_reg;
    assign abn = bn[EW-1] ? -bn : bn;
    assign abd = bd[EW-1] ? -bd : bd;
    assign agn = gn[EW-1] ? -gn : gn;
    assign agd = gd[EW-1] ? -gd : gd;
    assign bok = (bd != '0) && ((bn == '0) || (bn[EW-1] == bd[EW-1])) && (abn <= abd);
    assign gok = (gd != '0) && ((gn == '0) || (gn[EW-1] == gd[EW-1])) && (agn <= agd);

    logic v3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    tbcs_pkg::edge_res_t res_reg;
    always_ff @(posedge clk)
    begin
        res_reg.ok        <= tv2_reg && bok && gok;
        res_reg.beta_num  <= abn[MW-1:0];
        res_reg.beta_den  <= abd[MW-1:0];
        res_reg.gamma_num <= agn[MW-1:0];
        res_reg.gamma_den <= agd[MW-1:0];
    end

    assign out_valid = v3_reg;
    assign out_res   = res_reg;
endmodule
`default_nettype wire

@@ rtl/tbcs_div.sv @@
`default_nettype none
// pipelined restoring divider, one quotient bit per stage: floor(num*2^F/den), num<=den
module tbcs_div (
    input  wire logic                          clk,
    input  wire logic [tbcs_pkg::MW-1:0]       num,
    input  wire logic [tbcs_pkg::MW-1:0]       den,
    output logic      [tbcs_pkg::WW-1:0]       quo
);
    localparam int MW = tbcs_pkg::MW;
    localparam int WW = tbcs_pkg::WW;
    localparam int N  = tbcs_pkg::DIV_STEPS;

    logic [MW:0]   rem_reg [N];
    logic [MW-1:0] den_reg [N];
    logic [WW-1:0] q_reg   [N];

    // stage 0 takes the integer bit (num>=den)
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= (num >= den) ? {1'b0, num - den} : {1'b0, num};
        den_reg[0] <= den;
        q_reg[0]   <= WW'(num >= den);
    end

    for (genvar s = 1; s < N; s++)
    begin : g_step
        logic [MW+1:0] sh;
        logic          ge;
        assign sh = {rem_reg[s-1], 1'b0};
        assign ge = sh >= {2'b00, den_reg[s-1]};
        always_ff @(posedge clk)
        begin
            rem_reg[s] <= ge ? (MW+1)'(sh - {2'b00, den_reg[s-1]}) : (MW+1)'(sh);
            den_reg[s] <= den_reg[s-1];
            q_reg[s]   <= {q_reg[s-1][WW-2:0], ge};
        end
    end

    assign quo = q_reg[N-1];
endmodule
`default_nettype wire

@@ rtl/tbcs_blend.sv @@
`default_nettype none
// two stages: alpha and per-channel products, then sum with saturate
module tbcs_blend (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_ok,
    input  wire logic [tbcs_pkg::WW-1:0]  beta,
    input  wire logic [tbcs_pkg::WW-1:0]  gamma,
    input  wire tbcs_pkg::tri_cfg_t       cfg,
    output logic                          out_valid,
    output tbcs_pkg::color_t              out_color
);
    localparam int WW = tbcs_pkg::WW;
    localparam int F  = tbcs_pkg::WEIGHT_FRAC_BITS;
    localparam int PW = WW + 8;

    logic [WW:0] wsum, alpha;
    logic        cov;
    assign wsum  = {1'b0, beta} + {1'b0, gamma};
    assign cov   = in_ok && (wsum < (WW+1)'(1) << F);
    assign alpha = ((WW+1)'(1) << F) - wsum;

    logic v1_reg, cov_reg;
    logic [PW-1:0] pr_reg [9];
    logic [PW-1:0] pr_next [9];
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            pr_next[3*c]   = PW'(alpha[WW-1:0] * cfg.vertex_a_rgb[8*(2-c) +: 8]);
            pr_next[3*c+1] = PW'(beta * cfg.vertex_b_rgb[8*(2-c) +: 8]);
            pr_next[3*c+2] = PW'(gamma * cfg.vertex_c_rgb[8*(2-c) +: 8]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cov_reg <= cov;
        pr_reg  <= pr_next;
    end

    // sum, shift and saturate
    logic [7:0] ch [3];
    always_comb
    begin
        logic [PW+1:0] s;
        logic [PW+1:0] q;
        for (int c = 0; c < 3; c++)
        begin
            s = (PW+2)'(pr_reg[3*c]) + (PW+2)'(pr_reg[3*c+1]) + (PW+2)'(pr_reg[3*c+2]);
            q = s >> F;
            ch[c] = (q > (PW+2)'(255)) ? 8'hFF : q[7:0];
        end
    end

    logic v2_reg;
    tbcs_pkg::color_t col_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg  <= 1'b0;
            col_reg <= '0;
        end
        else
        begin
            v2_reg          <= v1_reg;
            col_reg.covered <= cov_reg;
            col_reg.red     <= cov_reg ? ch[0] : 8'h00;
            col_reg.green   <= cov_reg ? ch[1] : 8'h00;
            col_reg.blue    <= cov_reg ? ch[2] : 8'h00;
        end
    end

    assign out_valid = v2_reg;
    assign out_color = col_reg;
endmodule
`default_nettype wire

@@ rtl/triangle_barycentric_color_shader.sv @@
`default_nettype none
// from start to done: the edge multiplier stages, one divider stage per weight bit and the blend
// throughput: one pixel transaction per cycle, busy is always low
// the receiver cannot stall, so done/result are shown for exactly one cycle
// reset: asynchronous active-low rst_n clears config, valid flags and result to 0 and empties the pipeline
module triangle_barycentric_color_shader (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire tbcs_pkg::pixel_t  pixel,
    output logic                   done,
    output tbcs_pkg::color_t       result,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);
    localparam int N = tbcs_pkg::DIV_STEPS;

    tbcs_pkg::tri_cfg_t cfg_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbcs_pkg::REG_VERTEX_A_XY:    cfg_reg.vertex_a_xy    <= cfg_data;
                tbcs_pkg::REG_VERTEX_B_XY:    cfg_reg.vertex_b_xy    <= cfg_data;
                tbcs_pkg::REG_VERTEX_C_XY:    cfg_reg.vertex_c_xy    <= cfg_data;
                tbcs_pkg::REG_VERTEX_A_RGB:   cfg_reg.vertex_a_rgb   <= cfg_data[23:0];
                tbcs_pkg::REG_VERTEX_B_RGB:   cfg_reg.vertex_b_rgb   <= cfg_data[23:0];
                tbcs_pkg::REG_VERTEX_C_RGB:   cfg_reg.vertex_c_rgb   <= cfg_data[23:0];
                tbcs_pkg::REG_TRIANGLE_VALID: cfg_reg.triangle_valid <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic                edge_valid;
    tbcs_pkg::edge_res_t edge_res;

    tbcs_edge u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_pix    (pixel),
        .cfg       (cfg_reg),
        .out_valid (edge_valid),
        .out_res   (edge_res)
    );

    logic [tbcs_pkg::WW-1:0] beta, gamma;

    tbcs_div u_div_beta (
        .clk (clk),
        .num (edge_res.beta_num),
        .den (edge_res.beta_den),
        .quo (beta)
    );

    tbcs_div u_div_gamma (
        .clk (clk),
        .num (edge_res.gamma_num),
        .den (edge_res.gamma_den),
        .quo (gamma)
    );

    // valid and coverage flag ride alongside the divider stages
    logic vd_reg [N];
    logic ok_reg [N];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                vd_reg[i] <= 1'b0;
                ok_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vd_reg[0] <= edge_valid;
            ok_reg[0] <= edge_res.ok;
            for (int i = 1; i < N; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
                ok_reg[i] <= ok_reg[i-1];
            end
        end
    end

    tbcs_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vd_reg[N-1]),
        .in_ok     (ok_reg[N-1]),
        .beta      (beta),
        .gamma     (gamma),
        .cfg       (cfg_reg),
        .out_valid (done),
        .out_color (result)
    );
endmodule
`default_nettype wire
